// ----- rtl/assert_macros.svh -----
// assertion macros included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked each cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/prqs_pkg.sv -----
package prqs_pkg;
	localparam int LEVELS_DEF = 8;
	localparam int TASKS_DEF  = 16;
	localparam int FUNC_W   = 2;
	localparam int TID_W    = 4;
	localparam int PRIO_W   = 3;
	localparam int STATUS_W = 2;

	localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
	localparam logic [FUNC_W-1:0] FN_SWITCH = 2'd1;
	localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;
	localparam logic [FUNC_W-1:0] FN_BLOCK  = 2'd3;

	localparam logic [1:0] ST_ABSENT  = 2'd0;
	localparam logic [1:0] ST_READY   = 2'd1;
	localparam logic [1:0] ST_RUNNING = 2'd2;
	localparam logic [1:0] ST_BLOCKED = 2'd3;

	localparam logic [STATUS_W-1:0] RES_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] RES_REFUSED = 2'd1;
	localparam logic [STATUS_W-1:0] RES_IDLE    = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [TID_W-1:0]  task_id;
		logic [PRIO_W-1:0] priority_req;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TID_W-1:0]    running_task;
		logic                running_valid;
	} rsp_t;
endpackage

// ----- rtl/prqs_req_if.sv -----
interface prqs_req_if;
	import prqs_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// ----- rtl/prqs_rsp_if.sv -----
interface prqs_rsp_if;
	import prqs_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// ----- rtl/priority_ready_queue_scheduler_unit.sv -----
// Task scheduler with one linked FIFO ready queue per priority level. One request is
// handled at a time. Add, block and deletes of blocked or lone ready tasks settle in
// the decode state; switch probes one level per cycle from the top and reads the next
// link when the popped level holds other tasks; delete of another ready task pops it
// the same way when it heads its level, else walks the level list, one link memory
// read per step. The next links live in a one-port-read synchronous memory; per-task
// status and level and per-level head/tail are flip-flops.
// The result stays in an output register; the next request is taken once it leaves.
module priority_ready_queue_scheduler_unit #(
	parameter int LEVELS = prqs_pkg::LEVELS_DEF,
	parameter int TASKS  = prqs_pkg::TASKS_DEF
) (
	input logic clk,
	input logic arst_n,
	prqs_req_if.sink   req,
	prqs_rsp_if.source rsp
);
	import prqs_pkg::*;

	localparam int TW = $clog2(TASKS);
	localparam int LW = $clog2(LEVELS);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_SCAN, S_POP_RD, S_POP_WAIT, S_WALK_RD, S_WALK_WAIT,
		S_UNLINK_RD, S_UNLINK_WAIT, S_DONE
	} state_t;

	state_t state_q;
	req_t   req_q;
	rsp_t   rsp_q;
	logic   rsp_valid_q;

	logic [1:0]    tstat_q [TASKS];
	logic [LW-1:0] tlvl_q  [TASKS];
	logic [TW-1:0] head_q  [LEVELS];
	logic [TW-1:0] tail_q  [LEVELS];
	logic [LEVELS-1:0] nonempty_q;
	logic [TW-1:0] cur_q;
	logic          cur_valid_q;
	logic [LW-1:0] scan_q;
	logic [TW-1:0] walk_q;
	logic [TW:0]   steps_q;

	logic          ram_we;
	logic [TW-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

	prqs_ram #(.WIDTH(TW), .DEPTH(TASKS)) u_link (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	logic          id_ok, prio_ok;
	logic [TW-1:0] tid;
	logic [LW-1:0] plvl, dlvl;

	always_comb begin
		id_ok   = ({{(32-TID_W){1'b0}}, req_q.task_id} < 32'(TASKS));
		prio_ok = ({{(32-PRIO_W){1'b0}}, req_q.priority_req} < 32'(LEVELS));
		tid     = TW'(req_q.task_id);
		plvl    = LW'(req_q.priority_req);
		dlvl    = tlvl_q[tid];
	end

	// add/switch link writes land in the decision cycle, reads are issued ahead
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = walk_q;
		case (state_q)
			S_DECODE: begin
				if (req_q.func == FN_ADD && id_ok && prio_ok && tstat_q[tid] == ST_ABSENT
						&& nonempty_q[plvl]) begin
					ram_we = 1'b1;
					ram_waddr = tail_q[plvl];
					ram_wdata = tid;
				end
				if (req_q.func == FN_SWITCH && cur_valid_q && tstat_q[cur_q] == ST_RUNNING
						&& nonempty_q[tlvl_q[cur_q]]) begin
					ram_we = 1'b1;
					ram_waddr = tail_q[tlvl_q[cur_q]];
					ram_wdata = cur_q;
				end
			end
			S_POP_RD: ram_raddr = head_q[scan_q];
			S_UNLINK_RD: ram_raddr = tid;
			S_UNLINK_WAIT: begin
				ram_we = 1'b1;
				ram_waddr = walk_q;
				ram_wdata = ram_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
			nonempty_q <= '0;
			cur_q <= '0;
			cur_valid_q <= 1'b0;
			for (int i = 0; i < TASKS; i++) begin
				tstat_q[i] <= ST_ABSENT;
				tlvl_q[i] <= '0;
			end
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid && !rsp_valid_q) begin
						req_q <= req.data;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					rsp_q.status <= RES_REFUSED;
					state_q <= S_DONE;
					case (req_q.func)
						FN_ADD: begin
							if (id_ok && prio_ok && tstat_q[tid] == ST_ABSENT) begin
								if (!nonempty_q[plvl]) head_q[plvl] <= tid;
								tail_q[plvl] <= tid;
								nonempty_q[plvl] <= 1'b1;
								tstat_q[tid] <= ST_READY;
								tlvl_q[tid] <= plvl;
								rsp_q.status <= RES_OK;
							end
						end
						FN_SWITCH: begin
							if (cur_valid_q && tstat_q[cur_q] == ST_RUNNING) begin
								if (!nonempty_q[tlvl_q[cur_q]]) head_q[tlvl_q[cur_q]] <= cur_q;
								tail_q[tlvl_q[cur_q]] <= cur_q;
								nonempty_q[tlvl_q[cur_q]] <= 1'b1;
								tstat_q[cur_q] <= ST_READY;
							end
							cur_valid_q <= 1'b0;
							scan_q <= LW'(LEVELS - 1);
							state_q <= S_SCAN;
						end
						FN_DELETE: begin
							if (id_ok && tstat_q[tid] == ST_BLOCKED) begin
								tstat_q[tid] <= ST_ABSENT;
								rsp_q.status <= RES_OK;
							end else if (id_ok && tstat_q[tid] == ST_READY
									&& nonempty_q[dlvl]) begin
								if (head_q[dlvl] == tid) begin
									if (tail_q[dlvl] == tid) begin
										nonempty_q[dlvl] <= 1'b0;
										tstat_q[tid] <= ST_ABSENT;
										rsp_q.status <= RES_OK;
									end else begin
										scan_q <= dlvl;
										state_q <= S_POP_RD;
									end
								end else begin
									walk_q <= head_q[dlvl];
									steps_q <= '0;
									state_q <= S_WALK_RD;
								end
							end
						end
						default: begin
							if (cur_valid_q && tstat_q[cur_q] == ST_RUNNING) begin
								tstat_q[cur_q] <= ST_BLOCKED;
								cur_valid_q <= 1'b0;
								rsp_q.status <= RES_OK;
							end
						end
					endcase
				end
				S_SCAN: begin
					if (nonempty_q[scan_q]) begin
						if (head_q[scan_q] == tail_q[scan_q]) begin
							nonempty_q[scan_q] <= 1'b0;
							tstat_q[head_q[scan_q]] <= ST_RUNNING;
							cur_q <= head_q[scan_q];
							cur_valid_q <= 1'b1;
							rsp_q.status <= RES_OK;
							state_q <= S_DONE;
						end else begin
							state_q <= S_POP_RD;
						end
					end else if (scan_q == '0) begin
						rsp_q.status <= RES_IDLE;
						state_q <= S_DONE;
					end else begin
						scan_q <= scan_q - 1'b1;
					end
				end
				S_POP_RD: state_q <= S_POP_WAIT;
				S_POP_WAIT: begin
					head_q[scan_q] <= ram_rdata;
					rsp_q.status <= RES_OK;
					if (req_q.func == FN_SWITCH) begin
						tstat_q[head_q[scan_q]] <= ST_RUNNING;
						cur_q <= head_q[scan_q];
						cur_valid_q <= 1'b1;
					end else begin
						tstat_q[tid] <= ST_ABSENT;
					end
					state_q <= S_DONE;
				end
				S_WALK_RD: begin
					if (walk_q == tail_q[dlvl] || steps_q == (TW+1)'(TASKS))
						state_q <= S_DONE;
					else
						state_q <= S_WALK_WAIT;
				end
				S_WALK_WAIT: begin
					if (ram_rdata == tid) begin
						rsp_q.status <= RES_OK;
						tstat_q[tid] <= ST_ABSENT;
						if (tail_q[dlvl] == tid) begin
							tail_q[dlvl] <= walk_q;
							state_q <= S_DONE;
						end else begin
							state_q <= S_UNLINK_RD;
						end
					end else begin
						walk_q <= ram_rdata;
						steps_q <= steps_q + 1'b1;
						state_q <= S_WALK_RD;
					end
				end
				S_UNLINK_RD: state_q <= S_UNLINK_WAIT;
				S_UNLINK_WAIT: state_q <= S_DONE;
				default: begin
					rsp_q.running_task <= cur_valid_q ? TID_W'(cur_q) : '0;
					rsp_q.running_valid <= cur_valid_q;
					rsp_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;
endmodule

// ----- rtl/prqs_ram.sv -----
module prqs_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/prqs_checker.sv -----
`include "assert_macros.svh"
module prqs_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input prqs_pkg::rsp_t rsp_data
);
	import prqs_pkg::*;

	`ASSERT_IMPL(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, ##1 rsp_valid && $stable(rsp_data), "result dropped while stalled")
	`ASSERT_IMPL(a_no_take_busy, clk, arst_n, rsp_valid, !req_ready, "request taken while result pending")
	`ASSERT_IMPL(a_task_zero, clk, arst_n, rsp_valid && !rsp_data.running_valid, rsp_data.running_task == '0, "idle result shows a task")
	`ASSERT_CLK(a_status_code, clk, arst_n, !rsp_valid || rsp_data.status != 2'd3, "unknown status")
	`ASSERT_IMPL(a_one_result, clk, arst_n, req_valid && req_ready, ##1 !rsp_valid, "result too early")
endmodule

bind priority_ready_queue_scheduler_unit prqs_checker u_prqs_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
